// File: rtl/pfle_pkg.sv
package pfle_pkg;

	// command codes carried in s_tuser
	typedef enum logic [2:0] {
		OP_PIXEL = 3'd0,
		OP_LINE  = 3'd1,
		OP_READ  = 3'd2,
		OP_TAKE  = 3'd3,
		OP_CLEAR = 3'd4
	} opcode_t;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_PX_RD = 5'b00100,
		ST_PX_WR = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	// control from the sequencer to the line step unit
	typedef struct packed {
		logic load;
		logic advance;
	} step_ctl_t;

	// index of the last pixel a line may plot before it is cut off
	localparam logic [9:0] LINE_GUARD_LAST = 10'd599;

	// payload widths of the stream ports
	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 16;

endpackage

// File: rtl/pfle_ram.sv
module pfle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/pfle_step.sv
module pfle_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfle_pkg::step_ctl_t  ctl,
	input  logic [7:0]           x0,
	input  logic [7:0]           y0,
	input  logic [7:0]           x1,
	input  logic [7:0]           y1,
	output logic [7:0]           x,
	output logic [7:0]           y,
	output logic                 done
);

	logic [7:0]         x_q, y_q, x1_q, y1_q, dx_q, dy_q;
	logic               sx_neg_q, sy_neg_q;
	logic signed [10:0] err_q;
	logic signed [11:0] e2;
	logic               move_x, move_y;
	logic [7:0]         dx_init, dy_init;
	logic signed [10:0] err_next;

	assign dx_init = (x1 > x0) ? (x1 - x0) : (x0 - x1);
	assign dy_init = (y1 > y0) ? (y1 - y0) : (y0 - y1);

	// one bresenham decision per advance
	assign e2     = {err_q, 1'b0};
	assign move_x = e2 > -$signed({4'b0, dy_q});
	assign move_y = e2 < $signed({4'b0, dx_q});

	always_comb begin
		err_next = err_q;
		if (move_x) begin
			err_next = err_next - $signed({3'b0, dy_q});
		end
		if (move_y) begin
			err_next = err_next + $signed({3'b0, dx_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			x1_q     <= '0;
			y1_q     <= '0;
			dx_q     <= '0;
			dy_q     <= '0;
			sx_neg_q <= 1'b0;
			sy_neg_q <= 1'b0;
			err_q    <= '0;
		end else if (ctl.load) begin
			x_q      <= x0;
			y_q      <= y0;
			x1_q     <= x1;
			y1_q     <= y1;
			dx_q     <= dx_init;
			dy_q     <= dy_init;
			sx_neg_q <= !(x0 < x1);
			sy_neg_q <= !(y0 < y1);
			err_q    <= $signed({3'b0, dx_init}) - $signed({3'b0, dy_init});
		end else if (ctl.advance) begin
			err_q <= err_next;
			if (move_x) begin
				x_q <= sx_neg_q ? (x_q - 8'd1) : (x_q + 8'd1);
			end
			if (move_y) begin
				y_q <= sy_neg_q ? (y_q - 8'd1) : (y_q + 8'd1);
			end
		end
	end

	assign x    = x_q;
	assign y    = y_q;
	assign done = (x_q == x1_q) && (y_q == y1_q);

endmodule

// File: rtl/page_framebuffer_line_engine.sv
// Page-organised monochrome frame buffer with a line rasteriser. The screen is
// SCREEN_WIDTH columns by PAGE_COUNT*8 rows held in one SCREEN_WIDTH*PAGE_COUNT byte
// memory; each byte is 8 vertical pixels of one column in one page, bit n being
// row n of that page. An item on the input stream carries a command in s_tuser:
// set or clear one pixel, draw a line, read one byte, take the changed page range,
// or clear the buffer. Only read and take give a result item. The input is taken
// one item at a time: s_tready is high only while the sequencer is idle. A pixel
// is a read state and a write state (ST_PX_RD, ST_PX_WR) and a line one such pair
// per plotted point, each point being a read-modify-write through the single memory
// port pair with the shared bresenham step unit deciding the next point. For read
// and take the sequencer passes through ST_RESP before the result item is registered,
// waiting there while an earlier result is still held by m_tready. Clear
// writes one byte a cycle, all SCREEN_WIDTH*PAGE_COUNT bytes (1024 at default sizes);
// the same clearing pass runs after reset, and no item is accepted until it ends.
module page_framebuffer_line_engine #(
	parameter int SCREEN_WIDTH = 128,
	parameter int PAGE_COUNT   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], pixel_on[32],
	// read_page[35:33], read_column[42:36], zero fill up to 47
	input  logic [47:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// read_data[7:0], dirty_any[8], dirty_first[11:9], dirty_last[14:12], zero [15]
	output logic [15:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready
);

	localparam int DEPTH  = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int LOW_W  = $clog2(PAGE_COUNT + 1);
	localparam int HEIGHT = PAGE_COUNT * 8;

	// input item fields
	logic [7:0] x_start, y_start, x_end, y_end;
	logic       pixel_on;
	logic [2:0] read_page;
	logic [6:0] read_column;
	pfle_pkg::opcode_t opcode;

	assign x_start     = s_tdata[7:0];
	assign y_start     = s_tdata[15:8];
	assign x_end       = s_tdata[23:16];
	assign y_end       = s_tdata[31:24];
	assign pixel_on    = s_tdata[32];
	assign read_page   = s_tdata[35:33];
	assign read_column = s_tdata[42:36];
	assign opcode      = pfle_pkg::opcode_t'(s_tuser);

	pfle_pkg::state_t state_q;

	logic              accept;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [9:0]        guard_q;
	logic              pix_on_q;
	logic [ADDR_W-1:0] addr_q;
	logic              onscr_q;
	logic              rd_ok_q;
	logic              take_q;

	// dirty page tracking
	logic              mark_q;
	logic [LOW_W-1:0]  low_q;
	logic [PAGE_W-1:0] high_q;

	// output register
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic        out_free;

	// line step unit
	pfle_pkg::step_ctl_t step_ctl;
	logic [7:0] step_x, step_y;
	logic       step_done;
	logic       line_end;

	// shared address unit: page*SCREEN_WIDTH + column
	logic [4:0]        au_page;
	logic [7:0]        au_col;
	logic [ADDR_W-1:0] au_addr;
	logic              on_screen;
	logic              rd_in_range;

	// memory ports
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata, ram_rdata;
	logic [7:0]        pix_mask, pix_byte;

	// take result
	logic       take_full;
	logic [7:0] first_w, last_w;
	logic [2:0] take_first, take_last;

	assign s_tready = (state_q == pfle_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		if (state_q == pfle_pkg::ST_IDLE) begin
			au_page = {2'b0, read_page};
			au_col  = {1'b0, read_column};
		end else begin
			au_page = step_y[7:3];
			au_col  = step_x;
		end
	end

	assign au_addr = ADDR_W'(ADDR_W'(au_page) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(au_col);

	assign on_screen   = (9'(step_x) < 9'(SCREEN_WIDTH)) && (9'(step_y) < 9'(HEIGHT));
	assign rd_in_range = (5'(read_page) < 5'(PAGE_COUNT))
		&& (9'(read_column) < 9'(SCREEN_WIDTH));

	// the point is still held by the step unit while its byte is written
	assign pix_mask = 8'd1 << step_y[2:0];
	assign pix_byte = pix_on_q ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
	assign line_end = step_done || (guard_q == pfle_pkg::LINE_GUARD_LAST);

	assign step_ctl.load    = accept
		&& ((opcode == pfle_pkg::OP_PIXEL) || (opcode == pfle_pkg::OP_LINE));
	assign step_ctl.advance = (state_q == pfle_pkg::ST_PX_WR) && !line_end;

	assign ram_we    = (state_q == pfle_pkg::ST_CLEAR)
		|| ((state_q == pfle_pkg::ST_PX_WR) && onscr_q);
	assign ram_waddr = (state_q == pfle_pkg::ST_CLEAR) ? clr_addr_q : addr_q;
	assign ram_wdata = (state_q == pfle_pkg::ST_CLEAR) ? 8'd0 : pix_byte;
	assign ram_re    = (accept && (opcode == pfle_pkg::OP_READ) && rd_in_range)
		|| ((state_q == pfle_pkg::ST_PX_RD) && on_screen);

	// inverted or empty range falls back to the whole screen
	assign take_full  = (5'(low_q) >= 5'(PAGE_COUNT)) || (5'(low_q) > 5'(high_q));
	assign first_w    = take_full ? 8'd0 : 8'(low_q);
	assign last_w     = take_full ? 8'(PAGE_COUNT - 1) : 8'(high_q);
	assign take_first = mark_q ? first_w[2:0] : 3'd0;
	assign take_last  = mark_q ? last_w[2:0] : 3'd0;

	pfle_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (step_ctl),
		.x0     (x_start),
		.y0     (y_start),
		.x1     ((opcode == pfle_pkg::OP_PIXEL) ? x_start : x_end),
		.y1     ((opcode == pfle_pkg::OP_PIXEL) ? y_start : y_end),
		.x      (step_x),
		.y      (step_y),
		.done   (step_done)
	);

	pfle_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (au_addr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pfle_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			guard_q    <= '0;
			mark_q     <= 1'b0;
			low_q      <= LOW_W'(PAGE_COUNT);
			high_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving, else the taken one drops
			if ((state_q == pfle_pkg::ST_RESP) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				pfle_pkg::ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= pfle_pkg::ST_IDLE;
					end
				end
				pfle_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (opcode)
							pfle_pkg::OP_PIXEL, pfle_pkg::OP_LINE: begin
								guard_q <= '0;
								state_q <= pfle_pkg::ST_PX_RD;
							end
							pfle_pkg::OP_READ, pfle_pkg::OP_TAKE: begin
								state_q <= pfle_pkg::ST_RESP;
							end
							pfle_pkg::OP_CLEAR: begin
								mark_q     <= 1'b0;
								low_q      <= LOW_W'(PAGE_COUNT);
								high_q     <= '0;
								clr_addr_q <= '0;
								state_q    <= pfle_pkg::ST_CLEAR;
							end
							default: begin
								state_q <= pfle_pkg::ST_IDLE;
							end
						endcase
					end
				end
				pfle_pkg::ST_PX_RD: begin
					state_q <= pfle_pkg::ST_PX_WR;
				end
				pfle_pkg::ST_PX_WR: begin
					if (onscr_q) begin
						mark_q <= 1'b1;
						if (5'(step_y[7:3]) < 5'(low_q)) begin
							low_q <= LOW_W'(step_y[7:3]);
						end
						if (5'(step_y[7:3]) > 5'(high_q)) begin
							high_q <= PAGE_W'(step_y[7:3]);
						end
					end
					if (line_end) begin
						state_q <= pfle_pkg::ST_IDLE;
					end else begin
						guard_q <= guard_q + 10'd1;
						state_q <= pfle_pkg::ST_PX_RD;
					end
				end
				pfle_pkg::ST_RESP: begin
					if (out_free) begin
						state_q <= pfle_pkg::ST_IDLE;
						if (take_q) begin
							mark_q <= 1'b0;
							low_q  <= LOW_W'(PAGE_COUNT);
							high_q <= '0;
						end
					end
				end
				default: begin
					state_q <= pfle_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// per-item working registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_on_q <= pixel_on;
			rd_ok_q  <= rd_in_range;
			take_q   <= (opcode == pfle_pkg::OP_TAKE);
		end
		if (state_q == pfle_pkg::ST_PX_RD) begin
			addr_q  <= au_addr;
			onscr_q <= on_screen;
		end
		if ((state_q == pfle_pkg::ST_RESP) && out_free) begin
			if (take_q) begin
				m_tdata_q <= {1'b0, take_last, take_first, mark_q, 8'd0};
			end else begin
				m_tdata_q <= {8'd0, rd_ok_q ? ram_rdata : 8'd0};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: rtl/pfle_checker.sv
module pfle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [47:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] m_tdata,
	input logic        m_tvalid,
	input logic        m_tready
);

	logic busy_op;

	assign busy_op = (s_tuser == pfle_pkg::OP_PIXEL) || (s_tuser == pfle_pkg::OP_LINE)
		|| (s_tuser == pfle_pkg::OP_READ) || (s_tuser == pfle_pkg::OP_TAKE)
		|| (s_tuser == pfle_pkg::OP_CLEAR);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed under stall");

	// every real command takes the sequencer out of idle, so ready drops
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && busy_op |=> !s_tready)
		else $error("ready stayed high after a command");

	// a take result carries no byte
	a_take_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
		else $error("take result carries read data");

	// with nothing dirty the range is zero
	a_clean_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> m_tdata[15:9] == 7'd0)
		else $error("range reported without dirty mark");

endmodule

bind page_framebuffer_line_engine pfle_checker u_pfle_checker (.*);
